### rtl/amjs_pkg.sv
// Shared types and codes for the modem join-and-send sequencer.
package amjs_pkg;

	typedef enum logic [3:0] {
		ST_PROBE     = 4'd0,
		ST_MODE      = 4'd1,
		ST_DEV_CLASS = 4'd2,
		ST_RATE      = 4'd3,
		ST_PORT      = 4'd4,
		ST_JOIN      = 4'd5,
		ST_SYNC      = 4'd6,
		ST_CONN      = 4'd7,
		ST_LEN       = 4'd8,
		ST_SEND      = 4'd9
	} seq_state_t;

	typedef enum logic [3:0] {
		TX_NONE      = 4'd0,
		TX_PROBE     = 4'd1,
		TX_MODE      = 4'd2,
		TX_CLASS     = 4'd3,
		TX_RATE      = 4'd4,
		TX_JOIN      = 4'd5,
		TX_DTR       = 4'd6,
		TX_EMPTY_MSG = 4'd7,
		TX_RTC       = 4'd8,
		TX_LEN_QUERY = 4'd9,
		TX_PORT      = 4'd10,
		TX_PAYLOAD   = 4'd11
	} tx_cmd_t;

	typedef enum logic [1:0] {
		EV_TICK      = 2'd0,
		EV_LINE      = 2'd1,
		EV_PAYLOAD   = 2'd2,
		EV_LEN_QUERY = 2'd3
	} event_t;

	typedef enum logic [3:0] {
		RC_NONE           = 4'd0,
		RC_OK             = 4'd1,
		RC_MODE           = 4'd2,
		RC_CLASS          = 4'd3,
		RC_RATE           = 4'd4,
		RC_JOIN_FAIL      = 4'd5,
		RC_BUSY           = 4'd6,
		RC_JOINED         = 4'd7,
		RC_JOINED_ALREADY = 4'd8,
		RC_DTR            = 4'd9,
		RC_DONE           = 4'd10,
		RC_RTC            = 4'd11,
		RC_PORT           = 4'd12,
		RC_LEN            = 4'd13,
		RC_ACK            = 4'd14,
		RC_LEN_ERROR      = 4'd15
	} resp_code_t;

	typedef enum logic [2:0] {
		CFG_STEP_TIMEOUT       = 3'd0,
		CFG_JOIN_RETRY_PERIOD  = 3'd1,
		CFG_SYNC_RETRY_PERIOD  = 3'd2,
		CFG_LEN_TIMEOUT        = 3'd3,
		CFG_SEND_START_TIMEOUT = 3'd4,
		CFG_ACK_TIMEOUT        = 3'd5,
		CFG_MAX_ATTEMPTS       = 3'd6
	} cfg_index_t;

	localparam logic [7:0] STEP_TIMEOUT_RST       = 8'd3;
	localparam logic [7:0] JOIN_RETRY_PERIOD_RST  = 8'd30;
	localparam logic [7:0] SYNC_RETRY_PERIOD_RST  = 8'd30;
	localparam logic [7:0] LEN_TIMEOUT_RST        = 8'd10;
	localparam logic [7:0] SEND_START_TIMEOUT_RST = 8'd10;
	localparam logic [7:0] ACK_TIMEOUT_RST        = 8'd30;
	localparam logic [1:0] MAX_ATTEMPTS_RST       = 2'd3;
	localparam logic [7:0] MAX_LEN_RST            = 8'd50;
	localparam logic [7:0] TICK_MAX               = 8'd255;

	typedef struct packed {
		logic [7:0] step_timeout;
		logic [7:0] join_retry_period;
		logic [7:0] sync_retry_period;
		logic [7:0] len_timeout;
		logic [7:0] send_start_timeout;
		logic [7:0] ack_timeout;
		logic [1:0] max_attempts;
	} amjs_cfg_t;

	typedef struct packed {
		event_t     cmd;
		resp_code_t resp_code;
		logic       head_present;
		logic       head_len_ok;
		logic [7:0] head_port;
		logic       rtc_year_ok;
		logic       rtc_time_ok;
		logic       len_found;
		logic [7:0] len_value;
	} amjs_item_t;

	typedef struct packed {
		seq_state_t seq_state;
		logic [7:0] tick_count;
		logic [1:0] attempt_count;
		logic [7:0] max_len;
		logic [1:0] last_attempts;
	} amjs_state_t;

	typedef struct packed {
		tx_cmd_t    tx_cmd;
		logic [7:0] tx_port;
		logic       flush_rx;
		logic       post_sent;
		logic       post_error;
		logic       post_len_ready;
		logic       dequeue_payload;
		logic       set_time;
		logic       time_synced;
		logic [7:0] max_len;
		logic [1:0] last_attempts;
		seq_state_t seq_state;
	} amjs_result_t;

endpackage

### rtl/amjs_cfg_regs.sv
// Configuration register file: timeouts, retry periods and attempt limit.
module amjs_cfg_regs
	import amjs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output amjs_cfg_t  cfg
);

	amjs_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_timeout       <= STEP_TIMEOUT_RST;
			cfg_q.join_retry_period  <= JOIN_RETRY_PERIOD_RST;
			cfg_q.sync_retry_period  <= SYNC_RETRY_PERIOD_RST;
			cfg_q.len_timeout        <= LEN_TIMEOUT_RST;
			cfg_q.send_start_timeout <= SEND_START_TIMEOUT_RST;
			cfg_q.ack_timeout        <= ACK_TIMEOUT_RST;
			cfg_q.max_attempts       <= MAX_ATTEMPTS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_STEP_TIMEOUT:       cfg_q.step_timeout       <= cfg_data;
				CFG_JOIN_RETRY_PERIOD:  cfg_q.join_retry_period  <= cfg_data;
				CFG_SYNC_RETRY_PERIOD:  cfg_q.sync_retry_period  <= cfg_data;
				CFG_LEN_TIMEOUT:        cfg_q.len_timeout        <= cfg_data;
				CFG_SEND_START_TIMEOUT: cfg_q.send_start_timeout <= cfg_data;
				CFG_ACK_TIMEOUT:        cfg_q.ack_timeout        <= cfg_data;
				CFG_MAX_ATTEMPTS:       cfg_q.max_attempts       <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/amjs_step.sv
// Transition logic: event handler plus entry action of the new state.
module amjs_step
	import amjs_pkg::*;
(
	input  amjs_cfg_t    cfg,
	input  amjs_state_t  st,
	input  amjs_item_t   item,
	output amjs_state_t  st_next,
	output amjs_result_t res
);

	logic        is_tick;
	logic        is_line;
	logic [7:0]  bumped;
	seq_state_t  nxt;
	amjs_state_t hs;
	amjs_result_t ho;

	assign is_tick = (item.cmd == EV_TICK);
	assign is_line = (item.cmd == EV_LINE);
	// timer saturates, so a limit of 255 is never exceeded
	assign bumped  = (st.tick_count == TICK_MAX) ? st.tick_count : st.tick_count + 8'd1;

	// event handler
	always_comb begin
		hs  = st;
		ho  = '0;
		nxt = st.seq_state;
		case (st.seq_state)
			ST_PROBE: begin
				if (is_tick) ho.tx_cmd = TX_PROBE;
				else if (is_line && item.resp_code == RC_OK) nxt = ST_MODE;
			end
			ST_MODE, ST_DEV_CLASS, ST_RATE, ST_PORT: begin
				if (is_tick) begin
					hs.tick_count = bumped;
					if (bumped > cfg.step_timeout) nxt = ST_PROBE;
				end else if (is_line) begin
					if (st.seq_state == ST_MODE && item.resp_code == RC_MODE)
						nxt = ST_DEV_CLASS;
					else if (st.seq_state == ST_DEV_CLASS && item.resp_code == RC_CLASS)
						nxt = ST_RATE;
					else if (st.seq_state == ST_RATE && item.resp_code == RC_RATE)
						nxt = ST_JOIN;
					else if (st.seq_state == ST_PORT && item.resp_code == RC_PORT)
						nxt = ST_SEND;
				end
			end
			ST_JOIN: begin
				if (is_tick) begin
					hs.tick_count = bumped;
					if (bumped == cfg.join_retry_period) begin
						ho.tx_cmd     = TX_JOIN;
						hs.tick_count = '0;
					end
				end else if (is_line && (item.resp_code == RC_JOINED ||
				                         item.resp_code == RC_JOINED_ALREADY)) begin
					nxt = ST_SYNC;
				end
			end
			ST_SYNC: begin
				if (is_tick) begin
					hs.tick_count = bumped;
					if (bumped > cfg.sync_retry_period) begin
						ho.tx_cmd        = TX_DTR;
						hs.tick_count    = '0;
						hs.attempt_count = '0;
					end
				end else if (is_line) begin
					if (item.resp_code == RC_DTR) ho.tx_cmd = TX_EMPTY_MSG;
					else if (item.resp_code == RC_DONE) ho.tx_cmd = TX_RTC;
					else if (item.resp_code == RC_RTC && item.rtc_year_ok) begin
						ho.set_time    = 1'b1;
						ho.time_synced = 1'b1;
						if (item.rtc_time_ok) nxt = ST_CONN;
					end
				end
			end
			ST_CONN: begin
				if (item.cmd == EV_LEN_QUERY) nxt = ST_LEN;
				else if (item.cmd == EV_PAYLOAD) nxt = ST_PORT;
			end
			ST_LEN: begin
				if (is_tick) begin
					hs.tick_count = bumped;
					if (bumped > cfg.len_timeout) nxt = ST_CONN;
				end else if (is_line && item.resp_code == RC_LEN) begin
					if (item.len_found) hs.max_len = item.len_value;
					ho.post_len_ready = 1'b1;
					nxt = ST_CONN;
				end
			end
			ST_SEND: begin
				if (is_tick) begin
					hs.tick_count = bumped;
					if (st.attempt_count == 2'd0) begin
						if (bumped > cfg.send_start_timeout) begin
							ho.post_error = 1'b1;
							nxt = ST_CONN;
						end
					end else if (bumped > cfg.ack_timeout) begin
						if (st.attempt_count >= cfg.max_attempts) begin
							ho.dequeue_payload = 1'b1;
							ho.post_error      = 1'b1;
							nxt = ST_JOIN;
						end else if (item.head_present) begin
							// resend: restart ACK timer, count the attempt
							hs.tick_count    = '0;
							ho.flush_rx      = 1'b1;
							if (item.head_len_ok) ho.tx_cmd = TX_PAYLOAD;
							hs.attempt_count = st.attempt_count + 2'd1;
						end
					end
				end else if (is_line) begin
					if (item.resp_code == RC_ACK) begin
						hs.last_attempts   = st.attempt_count;
						ho.post_sent       = 1'b1;
						ho.dequeue_payload = 1'b1;
						nxt = ST_CONN;
					end else if (item.resp_code == RC_LEN_ERROR) begin
						ho.dequeue_payload = 1'b1;
						ho.post_error      = 1'b1;
						nxt = ST_CONN;
					end
				end
			end
			default: ;
		endcase
	end

	// entry action merged into the result when the state changes
	always_comb begin
		st_next = hs;
		res     = ho;
		st_next.seq_state = nxt;
		if (nxt != st.seq_state) begin
			st_next.tick_count    = '0;
			st_next.attempt_count = '0;
			res.flush_rx          = 1'b1;
			case (nxt)
				ST_MODE:      res.tx_cmd = TX_MODE;
				ST_DEV_CLASS: res.tx_cmd = TX_CLASS;
				ST_RATE:      res.tx_cmd = TX_RATE;
				ST_PORT: begin
					if (item.head_present) begin
						res.tx_cmd  = TX_PORT;
						res.tx_port = item.head_port;
					end
				end
				ST_JOIN:  res.tx_cmd = TX_JOIN;
				ST_SYNC:  res.tx_cmd = TX_DTR;
				ST_LEN:   res.tx_cmd = TX_LEN_QUERY;
				ST_SEND: begin
					if (item.head_present && item.head_len_ok) begin
						res.tx_cmd            = TX_PAYLOAD;
						st_next.attempt_count = 2'd1;
					end
				end
				default: ;
			endcase
		end
		res.max_len       = st_next.max_len;
		res.last_attempts = st_next.last_attempts;
		res.seq_state     = nxt;
	end

endmodule

### rtl/at_modem_join_send_sequencer.sv
// Top level of the modem join-and-send sequencer.
// Each accepted event (tick, classified response line, payload ready or length
// query) updates the sequencer state, tick timer and attempt counters in the
// cycle it is accepted and produces exactly one result in the next cycle in the
// output register: the command code to transmit, its port argument, the status
// pulses and the state after the event. Throughput is one event per cycle; the
// single output register holds a result while out_stall is high, and in_stall is
// raised only while that register is full and stalled. Configuration registers
// are written by the user through cfg_wr_en/cfg_index/cfg_data only while no
// event is in flight (unenforced); an index beyond the last register is ignored.
module at_modem_join_send_sequencer
	import amjs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [3:0] resp_code,
	input  logic       head_present,
	input  logic       head_len_ok,
	input  logic [7:0] head_port,
	input  logic       rtc_year_ok,
	input  logic       rtc_time_ok,
	input  logic       len_found,
	input  logic [7:0] len_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] tx_cmd,
	output logic [7:0] tx_port,
	output logic       flush_rx,
	output logic       post_sent,
	output logic       post_error,
	output logic       post_len_ready,
	output logic       dequeue_payload,
	output logic       set_time,
	output logic       time_synced,
	output logic [7:0] max_len_out,
	output logic [1:0] last_attempts_out,
	output logic [3:0] cur_state
);

	amjs_cfg_t    cfg;
	amjs_item_t   item;
	amjs_state_t  st_q;
	amjs_state_t  st_next;
	amjs_result_t res;
	amjs_result_t res_q;
	logic         out_valid_q;
	logic         accept;

	amjs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	always_comb begin
		item.cmd          = event_t'(cmd);
		item.resp_code    = resp_code_t'(resp_code);
		item.head_present = head_present;
		item.head_len_ok  = head_len_ok;
		item.head_port    = head_port;
		item.rtc_year_ok  = rtc_year_ok;
		item.rtc_time_ok  = rtc_time_ok;
		item.len_found    = len_found;
		item.len_value    = len_value;
	end

	amjs_step u_step (
		.cfg     (cfg),
		.st      (st_q),
		.item    (item),
		.st_next (st_next),
		.res     (res)
	);

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.seq_state     <= ST_PROBE;
			st_q.tick_count    <= '0;
			st_q.attempt_count <= '0;
			st_q.max_len       <= MAX_LEN_RST;
			st_q.last_attempts <= '0;
			out_valid_q        <= 1'b0;
		end else if (accept) begin
			st_q        <= st_next;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) res_q <= res;
	end

	assign out_valid         = out_valid_q;
	assign tx_cmd            = res_q.tx_cmd;
	assign tx_port           = res_q.tx_port;
	assign flush_rx          = res_q.flush_rx;
	assign post_sent         = res_q.post_sent;
	assign post_error        = res_q.post_error;
	assign post_len_ready    = res_q.post_len_ready;
	assign dequeue_payload   = res_q.dequeue_payload;
	assign set_time          = res_q.set_time;
	assign time_synced       = res_q.time_synced;
	assign max_len_out       = res_q.max_len;
	assign last_attempts_out = res_q.last_attempts;
	assign cur_state         = res_q.seq_state;

endmodule

### rtl/amjs_checker.sv
// Port-level assertions for the sequencer, bound to the top level.
module amjs_sva
	import amjs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] tx_cmd,
	input logic [7:0] tx_port,
	input logic       post_sent,
	input logic       dequeue_payload,
	input logic [3:0] cur_state
);

	// held result must stay presented
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// every accepted transaction yields a result next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted transaction gave no result");

	a_port_arg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_port != 8'd0 |-> tx_cmd == TX_PORT)
		else $error("port argument without port command");

	// an ACK always frees the payload and lands in connected
	a_sent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && post_sent |-> dequeue_payload && cur_state == ST_CONN)
		else $error("sent pulse without dequeue or connected state");

endmodule

bind at_modem_join_send_sequencer amjs_sva u_amjs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.tx_cmd          (tx_cmd),
	.tx_port         (tx_port),
	.post_sent       (post_sent),
	.dequeue_payload (dequeue_payload),
	.cur_state       (cur_state)
);

### tb/amjs_checker.sv
`timescale 1ns / 100ps
// Sequencer checker: tracks register writes, predicts each result and compares it.
module amjs_checker
	import amjs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [3:0] resp_code,
	input  logic       head_present,
	input  logic       head_len_ok,
	input  logic [7:0] head_port,
	input  logic       rtc_year_ok,
	input  logic       rtc_time_ok,
	input  logic       len_found,
	input  logic [7:0] len_value,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [3:0] tx_cmd,
	input  logic [7:0] tx_port,
	input  logic       flush_rx,
	input  logic       post_sent,
	input  logic       post_error,
	input  logic       post_len_ready,
	input  logic       dequeue_payload,
	input  logic       set_time,
	input  logic       time_synced,
	input  logic [7:0] max_len_out,
	input  logic [1:0] last_attempts_out,
	input  logic [3:0] cur_state,
	output int         fail_count,
	output int         results_owed,
	output seq_state_t predicted_state
);

	amjs_cfg_t    regs;
	logic [7:0]   ticks;
	logic [1:0]   tries;
	logic [7:0]   max_len;
	logic [1:0]   last_tries;
	amjs_result_t awaited_results[$];
	amjs_item_t   taken_event;
	amjs_result_t oldest;

	task automatic flag(input string msg);
		if (fail_count < 100)
			$display("%0t mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			flag($sformatf("%s got %0h want %0h", what, got, want));
	endtask

	// saturating second counter
	function automatic logic [7:0] bump_timer();
		if (ticks != TICK_MAX)
			ticks = ticks + 8'd1;
		return ticks;
	endfunction

	function automatic amjs_result_t sequence_event(input amjs_item_t ev);
		amjs_result_t r;
		seq_state_t   nxt;
		logic         tick;
		logic         line;
		r = '0;
		nxt = predicted_state;
		tick = (ev.cmd == EV_TICK);
		line = (ev.cmd == EV_LINE);
		case (predicted_state)
		ST_PROBE: begin
			if (tick)
				r.tx_cmd = TX_PROBE;
			else if (line && ev.resp_code == RC_OK)
				nxt = ST_MODE;
		end
		ST_MODE, ST_DEV_CLASS, ST_RATE, ST_PORT: begin
			if (tick) begin
				if (bump_timer() > regs.step_timeout)
					nxt = ST_PROBE;
			end else if (line) begin
				if (predicted_state == ST_MODE && ev.resp_code == RC_MODE)
					nxt = ST_DEV_CLASS;
				else if (predicted_state == ST_DEV_CLASS && ev.resp_code == RC_CLASS)
					nxt = ST_RATE;
				else if (predicted_state == ST_RATE && ev.resp_code == RC_RATE)
					nxt = ST_JOIN;
				else if (predicted_state == ST_PORT && ev.resp_code == RC_PORT)
					nxt = ST_SEND;
			end
		end
		ST_JOIN: begin
			if (tick) begin
				if (bump_timer() == regs.join_retry_period) begin
					r.tx_cmd = TX_JOIN;
					ticks = '0;
				end
			end else if (line && (ev.resp_code == RC_JOINED ||
					ev.resp_code == RC_JOINED_ALREADY)) begin
				nxt = ST_SYNC;
			end
		end
		ST_SYNC: begin
			if (tick) begin
				if (bump_timer() > regs.sync_retry_period) begin
					r.tx_cmd = TX_DTR;
					ticks = '0;
					tries = '0;
				end
			end else if (line) begin
				if (ev.resp_code == RC_DTR)
					r.tx_cmd = TX_EMPTY_MSG;
				else if (ev.resp_code == RC_DONE)
					r.tx_cmd = TX_RTC;
				else if (ev.resp_code == RC_RTC && ev.rtc_year_ok) begin
					r.set_time = 1'b1;
					r.time_synced = 1'b1;
					if (ev.rtc_time_ok)
						nxt = ST_CONN;
				end
			end
		end
		ST_CONN: begin
			if (ev.cmd == EV_LEN_QUERY)
				nxt = ST_LEN;
			else if (ev.cmd == EV_PAYLOAD)
				nxt = ST_PORT;
		end
		ST_LEN: begin
			if (tick) begin
				if (bump_timer() > regs.len_timeout)
					nxt = ST_CONN;
			end else if (line && ev.resp_code == RC_LEN) begin
				if (ev.len_found)
					max_len = ev.len_value;
				r.post_len_ready = 1'b1;
				nxt = ST_CONN;
			end
		end
		ST_SEND: begin
			if (tick) begin
				// no attempt yet means the first send never went out
				if (tries == 2'd0) begin
					if (bump_timer() > regs.send_start_timeout) begin
						r.post_error = 1'b1;
						nxt = ST_CONN;
					end
				end else if (bump_timer() > regs.ack_timeout) begin
					if (tries >= regs.max_attempts) begin
						r.dequeue_payload = 1'b1;
						r.post_error = 1'b1;
						nxt = ST_JOIN;
					end else if (ev.head_present) begin
						ticks = '0;
						r.flush_rx = 1'b1;
						if (ev.head_len_ok)
							r.tx_cmd = TX_PAYLOAD;
						tries = tries + 2'd1;
					end
				end
			end else if (line) begin
				if (ev.resp_code == RC_ACK) begin
					last_tries = tries;
					r.post_sent = 1'b1;
					r.dequeue_payload = 1'b1;
					nxt = ST_CONN;
				end else if (ev.resp_code == RC_LEN_ERROR) begin
					r.dequeue_payload = 1'b1;
					r.post_error = 1'b1;
					nxt = ST_CONN;
				end
			end
		end
		default: ;
		endcase

		// entry action of the new state merges into the same result
		if (nxt != predicted_state) begin
			predicted_state = nxt;
			ticks = '0;
			tries = '0;
			r.flush_rx = 1'b1;
			case (nxt)
			ST_MODE:      r.tx_cmd = TX_MODE;
			ST_DEV_CLASS: r.tx_cmd = TX_CLASS;
			ST_RATE:      r.tx_cmd = TX_RATE;
			ST_PORT: begin
				if (ev.head_present) begin
					r.tx_cmd = TX_PORT;
					r.tx_port = ev.head_port;
				end
			end
			ST_JOIN:  r.tx_cmd = TX_JOIN;
			ST_SYNC:  r.tx_cmd = TX_DTR;
			ST_LEN:   r.tx_cmd = TX_LEN_QUERY;
			ST_SEND: begin
				if (ev.head_present && ev.head_len_ok) begin
					r.tx_cmd = TX_PAYLOAD;
					tries = 2'd1;
				end
			end
			default: ;
			endcase
		end
		r.max_len = max_len;
		r.last_attempts = last_tries;
		r.seq_state = predicted_state;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predicted_state = ST_PROBE;
			ticks = '0;
			tries = '0;
			max_len = MAX_LEN_RST;
			last_tries = '0;
			regs = '{STEP_TIMEOUT_RST, JOIN_RETRY_PERIOD_RST, SYNC_RETRY_PERIOD_RST,
				LEN_TIMEOUT_RST, SEND_START_TIMEOUT_RST, ACK_TIMEOUT_RST, MAX_ATTEMPTS_RST};
			awaited_results.delete();
			results_owed = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
				CFG_STEP_TIMEOUT:       regs.step_timeout = cfg_data;
				CFG_JOIN_RETRY_PERIOD:  regs.join_retry_period = cfg_data;
				CFG_SYNC_RETRY_PERIOD:  regs.sync_retry_period = cfg_data;
				CFG_LEN_TIMEOUT:        regs.len_timeout = cfg_data;
				CFG_SEND_START_TIMEOUT: regs.send_start_timeout = cfg_data;
				CFG_ACK_TIMEOUT:        regs.ack_timeout = cfg_data;
				CFG_MAX_ATTEMPTS:       regs.max_attempts = cfg_data[1:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				taken_event = {cmd, resp_code, head_present, head_len_ok, head_port,
					rtc_year_ok, rtc_time_ok, len_found, len_value};
				awaited_results.push_back(sequence_event(taken_event));
			end
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					flag("result with no transaction outstanding");
				end else begin
					oldest = awaited_results.pop_front();
					check_field("tx_cmd", 8'(tx_cmd), 8'(oldest.tx_cmd));
					check_field("tx_port", tx_port, oldest.tx_port);
					check_field("flush_rx", 8'(flush_rx), 8'(oldest.flush_rx));
					check_field("post_sent", 8'(post_sent), 8'(oldest.post_sent));
					check_field("post_error", 8'(post_error), 8'(oldest.post_error));
					check_field("post_len_ready", 8'(post_len_ready),
						8'(oldest.post_len_ready));
					check_field("dequeue_payload", 8'(dequeue_payload),
						8'(oldest.dequeue_payload));
					check_field("set_time", 8'(set_time), 8'(oldest.set_time));
					check_field("time_synced", 8'(time_synced), 8'(oldest.time_synced));
					check_field("max_len_out", max_len_out, oldest.max_len);
					check_field("last_attempts_out", 8'(last_attempts_out),
						8'(oldest.last_attempts));
					check_field("cur_state", 8'(cur_state), 8'(oldest.seq_state));
				end
			end
			results_owed = awaited_results.size();
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Sequencer testbench top: clock, reset, event stimulus, back-pressure and the verdict.
module testbench;
	import amjs_pkg::*;

	localparam int N_PHASES    = 7;
	localparam int CALM_PHASE  = 2;
	localparam int SAT_PHASE   = 4;
	localparam int PHASE_ITEMS = 55;
	localparam int HOLD_CYCLES = 60;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] cmd;
	logic [3:0] resp_code;
	logic       head_present;
	logic       head_len_ok;
	logic [7:0] head_port;
	logic       rtc_year_ok;
	logic       rtc_time_ok;
	logic       len_found;
	logic [7:0] len_value;
	logic       out_valid;
	logic       out_stall;
	logic [3:0] tx_cmd;
	logic [7:0] tx_port;
	logic       flush_rx;
	logic       post_sent;
	logic       post_error;
	logic       post_len_ready;
	logic       dequeue_payload;
	logic       set_time;
	logic       time_synced;
	logic [7:0] max_len_out;
	logic [1:0] last_attempts_out;
	logic [3:0] cur_state;

	int         fail_count;
	int         results_owed;
	seq_state_t predicted_state;

	int idle_pct = 24;
	int hold_requests = 0;
	int holds_done = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	at_modem_join_send_sequencer u_top (.*);
	amjs_checker u_checker (.*);

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// receiver side: random stalls, plus long hold-offs on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_done < hold_requests) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < idle_pct);
			end
		end
	end

	function automatic amjs_item_t random_event();
		logic [31:0] raw;
		raw = $urandom;
		return raw[$bits(amjs_item_t)-1:0];
	endfunction

	function automatic amjs_item_t shaped(input event_t c, input resp_code_t rc);
		amjs_item_t ev;
		ev = random_event();
		ev.cmd = c;
		ev.resp_code = rc;
		return ev;
	endfunction

	// mostly the event that moves the current state forward, some ticks, some noise
	function automatic amjs_item_t pick_event(input seq_state_t s, input int noise_pct,
			input int tick_pct);
		amjs_item_t ev;
		int         dice;
		dice = $urandom_range(0, 99);
		if (dice < noise_pct)
			return random_event();
		ev = shaped(EV_TICK, RC_NONE);
		ev.head_present = ($urandom_range(0, 99) < 85);
		ev.head_len_ok = ($urandom_range(0, 99) < 85);
		if (dice < noise_pct + tick_pct)
			return ev;
		ev.cmd = EV_LINE;
		case (s)
		ST_PROBE:     ev.resp_code = RC_OK;
		ST_MODE:      ev.resp_code = RC_MODE;
		ST_DEV_CLASS: ev.resp_code = RC_CLASS;
		ST_RATE:      ev.resp_code = RC_RATE;
		ST_PORT:      ev.resp_code = RC_PORT;
		ST_JOIN:  ev.resp_code = $urandom_range(0, 1) ? RC_JOINED : RC_JOINED_ALREADY;
		ST_SYNC: begin
			case ($urandom_range(0, 3))
			0: ev.resp_code = RC_DTR;
			1: ev.resp_code = RC_DONE;
			default: ev.resp_code = RC_RTC;
			endcase
			ev.rtc_year_ok = ($urandom_range(0, 99) < 80);
			ev.rtc_time_ok = ($urandom_range(0, 99) < 70);
		end
		ST_CONN: ev.cmd = $urandom_range(0, 1) ? EV_PAYLOAD : EV_LEN_QUERY;
		ST_LEN: begin
			ev.resp_code = RC_LEN;
			ev.len_found = ($urandom_range(0, 99) < 70);
		end
		ST_SEND: begin
			case ($urandom_range(0, 5))
			0, 1: ev.resp_code = RC_ACK;
			2: ev.resp_code = RC_LEN_ERROR;
			default: ev.cmd = EV_TICK;
			endcase
		end
		default: ;
		endcase
		return ev;
	endfunction

	function automatic amjs_cfg_t phase_regs(input int p);
		amjs_cfg_t c;
		case (p)
		0: c = '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 2'd1};
		1: c = '{8'd2, 8'd3, 8'd2, 8'd3, 8'd2, 8'd2, 2'd2};
		// join never resent, payload dropped at the first ack timeout
		3: c = '{8'd4, 8'd0, 8'd3, 8'd3, 8'd3, 8'd1, 2'd0};
		4: c = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 2'd3};
		6: c = '{STEP_TIMEOUT_RST, JOIN_RETRY_PERIOD_RST, SYNC_RETRY_PERIOD_RST,
			LEN_TIMEOUT_RST, SEND_START_TIMEOUT_RST, ACK_TIMEOUT_RST, MAX_ATTEMPTS_RST};
		default: begin
			c.step_timeout = 8'($urandom_range(1, 12));
			c.join_retry_period = 8'($urandom_range(1, 12));
			c.sync_retry_period = 8'($urandom_range(1, 12));
			c.len_timeout = 8'($urandom_range(1, 12));
			c.send_start_timeout = 8'($urandom_range(1, 12));
			c.ack_timeout = 8'($urandom_range(1, 12));
			c.max_attempts = 2'($urandom_range(1, 3));
		end
		endcase
		return c;
	endfunction

	// entered and left at a falling edge
	task automatic offer(input amjs_item_t ev);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= ev.cmd;
		resp_code <= ev.resp_code;
		head_present <= ev.head_present;
		head_len_ok <= ev.head_len_ok;
		head_port <= ev.head_port;
		rtc_year_ok <= ev.rtc_year_ok;
		rtc_time_ok <= ev.rtc_time_ok;
		len_found <= ev.len_found;
		len_value <= ev.len_value;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		wait (results_owed == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic program_regs(input amjs_cfg_t c);
		write_reg(CFG_STEP_TIMEOUT, c.step_timeout);
		write_reg(CFG_JOIN_RETRY_PERIOD, c.join_retry_period);
		write_reg(CFG_SYNC_RETRY_PERIOD, c.sync_retry_period);
		write_reg(CFG_LEN_TIMEOUT, c.len_timeout);
		write_reg(CFG_SEND_START_TIMEOUT, c.send_start_timeout);
		write_reg(CFG_ACK_TIMEOUT, c.ack_timeout);
		write_reg(CFG_MAX_ATTEMPTS, {6'd0, c.max_attempts});
		cfg_wr_en <= 1'b0;
	endtask

	// one pass through the whole join and send flow with the reset settings
	task automatic run_directed();
		amjs_item_t ev;
		offer(shaped(EV_TICK, RC_NONE));
		offer(shaped(EV_LINE, RC_NONE));
		offer(shaped(EV_LINE, RC_OK));
		offer(shaped(EV_PAYLOAD, RC_MODE));
		offer(shaped(EV_LINE, RC_MODE));
		offer(shaped(EV_LINE, RC_CLASS));
		offer(shaped(EV_LINE, RC_RATE));
		offer(shaped(EV_LINE, RC_JOIN_FAIL));
		offer(shaped(EV_LINE, RC_BUSY));
		offer(shaped(EV_LINE, RC_JOINED));
		offer(shaped(EV_LINE, RC_DTR));
		offer(shaped(EV_LINE, RC_DONE));
		// clock reply: bad year, then good year with a bad stamp, then both good
		ev = shaped(EV_LINE, RC_RTC);
		ev.rtc_year_ok = 1'b0;
		offer(ev);
		ev.rtc_year_ok = 1'b1;
		ev.rtc_time_ok = 1'b0;
		offer(ev);
		ev.rtc_time_ok = 1'b1;
		offer(ev);
		offer(shaped(EV_LEN_QUERY, RC_NONE));
		ev = shaped(EV_LINE, RC_LEN);
		ev.len_found = 1'b0;
		offer(ev);
		offer(shaped(EV_LEN_QUERY, RC_NONE));
		ev.len_found = 1'b1;
		ev.len_value = 8'hFF;
		offer(ev);
		// port and send entry with nothing usable at the head
		ev = shaped(EV_PAYLOAD, RC_NONE);
		ev.head_present = 1'b0;
		offer(ev);
		ev = shaped(EV_LINE, RC_PORT);
		ev.head_present = 1'b1;
		ev.head_len_ok = 1'b0;
		offer(ev);
		offer(shaped(EV_LINE, RC_LEN_ERROR));
		ev = shaped(EV_PAYLOAD, RC_NONE);
		ev.head_present = 1'b1;
		ev.head_port = 8'hFF;
		offer(ev);
		ev = shaped(EV_LINE, RC_PORT);
		ev.head_present = 1'b1;
		ev.head_len_ok = 1'b1;
		offer(ev);
		offer(shaped(EV_LINE, RC_ACK));
		offer(shaped(EV_LEN_QUERY, RC_NONE));
		ev = shaped(EV_LINE, RC_LEN);
		ev.len_found = 1'b1;
		ev.len_value = 8'h00;
		offer(ev);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = '0;
		resp_code = '0;
		head_present = 1'b0;
		head_len_ok = 1'b0;
		head_port = '0;
		rtc_year_ok = 1'b0;
		rtc_time_ok = 1'b0;
		len_found = 1'b0;
		len_value = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		settle();

		for (int p = 0; p < N_PHASES; p++) begin
			program_regs(phase_regs(p));
			idle_pct = (p == CALM_PHASE) ? 0 : 24;
			if (p == 1 || p == 5)
				hold_requests++;
			if (p == SAT_PHASE) begin
				// park in a timed state, then run its timer into saturation; in join it restarts at its period instead
				while (predicted_state == ST_PROBE || predicted_state == ST_CONN ||
						predicted_state == ST_SEND)
					offer(pick_event(predicted_state, 0, 0));
				repeat (300) offer(shaped(EV_TICK, RC_NONE));
			end
			repeat (PHASE_ITEMS) offer(pick_event(predicted_state, 20, 25));
			settle();
		end

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### at_modem_join_send_sequencer.f
rtl/amjs_pkg.sv
rtl/amjs_cfg_regs.sv
rtl/amjs_step.sv
rtl/at_modem_join_send_sequencer.sv
rtl/amjs_checker.sv
tb/amjs_checker.sv
tb/testbench.sv
